// ===== rtl/s2cd_pkg.sv =====
// Shared types and constants for the seconds-to-calendar-date converter.
// Used by the stage control, the top level and the port checker.
`default_nettype none

package s2cd_pkg;

   // Payload widths
   localparam int TIME_BITS_DEF = 38;
   localparam int YEAR_W        = 14;
   localparam int MONTH_W       = 4;
   localparam int DAY_W         = 5;
   localparam int HOUR_W        = 5;
   localparam int MINUTE_W      = 6;
   localparam int SECOND_W      = 6;

   // Pipeline depth, request to response register
   localparam int NUM_STAGES = 11;

   // Internal widths of the date path
   localparam int ZW     = 22;   // Julian day number
   localparam int TODW   = 17;   // second of the day
   localparam int MODW   = 11;   // minute of the day
   localparam int NAW    = 24;   // 4z - 7468865
   localparam int ALPHAW = 7;
   localparam int NCW    = 27;   // 20b - 2442
   localparam int CW     = 14;
   localparam int XW     = 9;    // b - d, day in the March-based year
   localparam int EW     = 4;

   // Calendar constants
   localparam int SEC_LO_BITS     = 7;        // 86400 = 128 * 675
   localparam int SEC_HI_DIV      = 675;
   localparam int SEC_HI_BITS     = 10;
   localparam int DAY_NUMBER_1970 = 2440588;
   localparam int GREGORIAN_START = 2299161;
   localparam int ALPHA_BIAS      = 7468865;
   localparam int ALPHA_DIV       = 146097;
   localparam int B_BIAS          = 1524;
   localparam int C_MUL           = 20;
   localparam int C_BIAS          = 2442;
   localparam int C_DIV           = 7305;
   localparam int D_MUL           = 1461;
   localparam int E_MUL           = 10000;
   localparam int E_DIV           = 306001;
   localparam int SIXTY           = 60;
   localparam int YEAR_BIAS_LATE  = 4716;   // March..December
   localparam int YEAR_BIAS_EARLY = 4715;   // January, February
   localparam int MONTH_WRAP      = 14;

   // Exact reciprocals: ceil(2^k / d), k = numerator bits + divisor bits
   localparam int ALPHA_SH = 42;
   localparam logic [24:0] ALPHA_RECIP =
      25'(((64'd1 << ALPHA_SH) + 64'(ALPHA_DIV) - 64'd1) / 64'(ALPHA_DIV));
   localparam int C_SH = 40;
   localparam logic [27:0] C_RECIP =
      28'(((64'd1 << C_SH) + 64'(C_DIV) - 64'd1) / 64'(C_DIV));
   // 10000 folded into the reciprocal of 306001
   localparam int E_SH = 42;
   localparam logic [37:0] E_RECIP =
      38'((((64'd1 << E_SH) + 64'(E_DIV) - 64'd1) / 64'(E_DIV)) * 64'(E_MUL));
   localparam int SIXTY_SH = 23;
   localparam logic [17:0] SIXTY_RECIP =
      18'(((64'd1 << SIXTY_SH) + 64'(SIXTY) - 64'd1) / 64'(SIXTY));

   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } hms_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] valid;
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

   // floor(30.6001 * e) for the month numbers that occur
   function automatic logic [XW-1:0] month_start(input logic [EW-1:0] e);
      logic [XW-1:0] r;
      begin
         case (e)
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd183;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd244;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd336;
            4'd12:   r = 9'd367;
            4'd13:   r = 9'd397;
            4'd14:   r = 9'd428;
            4'd15:   r = 9'd459;
            default: r = 9'd0;
         endcase
         return r;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/s2cd_pipe_ctl.sv =====
// Stage valid bits and per-stage load enables for the converter pipeline.
// Depends on s2cd_pkg (NUM_STAGES, pipe_ctl_type).
`default_nettype none

module s2cd_pipe_ctl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic                 out_ready,
   output s2cd_pkg::pipe_ctl_type    ctl
);
   import s2cd_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   // a stage loads when it is empty or its content moves on this cycle
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (load[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = load[0];
   assign ctl.valid = valid_ff;
   assign ctl.load  = load;

endmodule

`default_nettype wire

// ===== rtl/seconds_to_calendar_date.sv =====
// Throughput one item per cycle unless rsp_ready stalls the pipe.
// The stages hold the chain of reciprocal multipliers (675, 146097, 7305, 306001) and the divides
// by 60, each with a register behind it, plus the bias, remainder and calendar fix-up steps;
// the last stage is the response register. Stalls on rsp_ready back up stage by stage; empty
// stages are filled, nothing is dropped. Reset (synchronous, active high) clears all stage valid
// bits; payload is not reset. Depends on s2cd_pkg and s2cd_pipe_ctl.
`default_nettype none

module seconds_to_calendar_date #(
   parameter int TIME_BITS = s2cd_pkg::TIME_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [TIME_BITS-1:0]         req_unix_seconds,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [s2cd_pkg::YEAR_W-1:0]       rsp_year,
   output logic        [s2cd_pkg::MONTH_W-1:0]      rsp_month,
   output logic        [s2cd_pkg::DAY_W-1:0]        rsp_day_of_month,
   output logic        [s2cd_pkg::HOUR_W-1:0]       rsp_hour,
   output logic        [s2cd_pkg::MINUTE_W-1:0]     rsp_minute,
   output logic        [s2cd_pkg::SECOND_W-1:0]     rsp_second
);
   import s2cd_pkg::*;

   // Day split: s = 128*q1 + r1, q1 = 675*days' + r. q1 is biased by a multiple
   // of 675 so the division runs on an unsigned value; the bias comes back out
   // in the day-number offset.
   localparam int Q1W = TIME_BITS - SEC_LO_BITS;
   localparam int UW  = Q1W + 1;
   localparam int QW  = UW - 9;
   localparam int PW  = 2 * UW + 1;
   localparam int U_SH = UW + SEC_HI_BITS;
   localparam logic [UW-1:0] SEC_OFS =
      UW'(64'(SEC_HI_DIV) << (Q1W - SEC_HI_BITS));
   localparam logic [UW:0] SEC_RECIP =
      (UW+1)'(((64'd1 << U_SH) + 64'(SEC_HI_DIV) - 64'd1) / 64'(SEC_HI_DIV));
   localparam logic [ZW-1:0] DAY_OFS =
      ZW'(64'(DAY_NUMBER_1970) - (64'd1 << (Q1W - SEC_HI_BITS)));

   pipe_ctl_type ctl;

   s2cd_pipe_ctl u_pipe_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .out_ready (rsp_ready),
      .ctl       (ctl)
   );

   assign rsp_valid = ctl.valid[NUM_STAGES-1];

   // ---------------------------------------------------------------------
   // Stage 1: floor by 128 (arithmetic shift), bias for the 675 divide
   // ---------------------------------------------------------------------
   logic signed [Q1W-1:0]      s1_q1;
   logic [UW-1:0]              s1_u_in, s1_u_ff;
   logic [SEC_LO_BITS-1:0]     s1_r1_ff;

   always_comb begin
      s1_q1   = $signed(req_unix_seconds[TIME_BITS-1:SEC_LO_BITS]);
      s1_u_in = $unsigned(UW'(s1_q1)) + SEC_OFS;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         s1_u_ff  <= s1_u_in;
         s1_r1_ff <= req_unix_seconds[SEC_LO_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: quotient by 675 through the exact reciprocal
   // ---------------------------------------------------------------------
   logic [PW-1:0]              s2_prod;
   logic [QW-1:0]              s2_q_ff;
   logic [SEC_HI_BITS-1:0]     s2_ulo_ff;
   logic [SEC_LO_BITS-1:0]     s2_r1_ff;

   always_comb begin
      s2_prod = PW'(s1_u_ff) * PW'(SEC_RECIP);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         s2_q_ff   <= s2_prod[U_SH +: QW];
         s2_ulo_ff <= s1_u_ff[SEC_HI_BITS-1:0];
         s2_r1_ff  <= s1_r1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: remainder (fits in 10 bits), day number, second of day
   // ---------------------------------------------------------------------
   logic [QW+SEC_HI_BITS-1:0]  s3_qm;
   logic [SEC_HI_BITS-1:0]     s3_r;
   logic [ZW-1:0]              s3_z_in, s3_z_ff;
   logic [TODW-1:0]            s3_tod_ff;

   always_comb begin
      s3_qm   = (QW+SEC_HI_BITS)'(s2_q_ff) * (QW+SEC_HI_BITS)'(SEC_HI_DIV);
      s3_r    = s2_ulo_ff - s3_qm[SEC_HI_BITS-1:0];
      s3_z_in = ZW'(s2_q_ff) + DAY_OFS;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         s3_z_ff   <= s3_z_in;
         s3_tod_ff <= {s3_r, s2_r1_ff};
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: calendar select, alpha numerator, minute of day
   // ---------------------------------------------------------------------
   logic [TODW+17:0]           s4_mprod;
   logic [ZW-1:0]              s4_z_ff;
   logic                       s4_greg_ff;
   logic [NAW-1:0]             s4_na_ff;
   logic [MODW-1:0]            s4_mod_ff;
   logic [TODW-1:0]            s4_tod_ff;

   always_comb begin
      s4_mprod = (TODW+18)'(s3_tod_ff) * (TODW+18)'(SIXTY_RECIP);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         s4_z_ff    <= s3_z_ff;
         s4_greg_ff <= (s3_z_ff >= ZW'(GREGORIAN_START));
         // only meaningful on the Gregorian side
         s4_na_ff   <= {s3_z_ff, 2'b00} - NAW'(ALPHA_BIAS);
         s4_mod_ff  <= s4_mprod[SIXTY_SH +: MODW];
         s4_tod_ff  <= s3_tod_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: alpha, hour, second
   // ---------------------------------------------------------------------
   logic [NAW+24:0]            s5_aprod;
   logic [MODW+17:0]           s5_hprod;
   logic [MODW+5:0]            s5_m60;
   logic [ZW-1:0]              s5_z_ff;
   logic                       s5_greg_ff;
   logic [ALPHAW-1:0]          s5_alpha_ff;
   logic [MODW-1:0]            s5_mod_ff;
   hms_type                    s5_hms_in, s5_hms_ff;

   always_comb begin
      s5_aprod = (NAW+25)'(s4_na_ff) * (NAW+25)'(ALPHA_RECIP);
      s5_hprod = (MODW+18)'(s4_mod_ff) * (MODW+18)'(SIXTY_RECIP);
      s5_m60   = (MODW+6)'(s4_mod_ff) * (MODW+6)'(SIXTY);
      s5_hms_in.hour   = s5_hprod[SIXTY_SH +: HOUR_W];
      s5_hms_in.minute = '0;
      s5_hms_in.second = s4_tod_ff[SECOND_W-1:0] - s5_m60[SECOND_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         s5_z_ff     <= s4_z_ff;
         s5_greg_ff  <= s4_greg_ff;
         s5_alpha_ff <= s5_aprod[ALPHA_SH +: ALPHAW];
         s5_mod_ff   <= s4_mod_ff;
         s5_hms_ff   <= s5_hms_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: b = a + 1524, minute
   // ---------------------------------------------------------------------
   logic [ZW-1:0]              s6_corr;
   logic [HOUR_W+5:0]          s6_h60;
   logic [ZW-1:0]              s6_b_in, s6_b_ff;
   hms_type                    s6_hms_in, s6_hms_ff;

   always_comb begin
      // Gregorian correction 1 + alpha - floor(alpha/4), none before the switch
      s6_corr = s5_greg_ff
              ? (ZW'(s5_alpha_ff) + ZW'(1) - ZW'(s5_alpha_ff >> 2))
              : '0;
      s6_b_in = s5_z_ff + ZW'(B_BIAS) + s6_corr;
      s6_h60  = (HOUR_W+6)'(s5_hms_ff.hour) * (HOUR_W+6)'(SIXTY);
      s6_hms_in        = s5_hms_ff;
      s6_hms_in.minute = s5_mod_ff[MINUTE_W-1:0] - s6_h60[MINUTE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         s6_b_ff   <= s6_b_in;
         s6_hms_ff <= s6_hms_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 7: 20b - 2442
   // ---------------------------------------------------------------------
   logic [NCW-1:0]             s7_nc_ff;
   logic [ZW-1:0]              s7_b_ff;
   hms_type                    s7_hms_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[6]) begin
         s7_nc_ff  <= NCW'(s6_b_ff) * NCW'(C_MUL) - NCW'(C_BIAS);
         s7_b_ff   <= s6_b_ff;
         s7_hms_ff <= s6_hms_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 8: c = floor((20b - 2442) / 7305)
   // ---------------------------------------------------------------------
   logic [NCW+27:0]            s8_cprod;
   logic [CW-1:0]              s8_c_ff;
   logic [ZW-1:0]              s8_b_ff;
   hms_type                    s8_hms_ff;

   always_comb begin
      s8_cprod = (NCW+28)'(s7_nc_ff) * (NCW+28)'(C_RECIP);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[7]) begin
         s8_c_ff   <= s8_cprod[C_SH +: CW];
         s8_b_ff   <= s7_b_ff;
         s8_hms_ff <= s7_hms_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 9: x = b - floor(1461c / 4), never below 123, always within 122..488
   // ---------------------------------------------------------------------
   logic [CW+10:0]             s9_dprod;
   logic [XW-1:0]              s9_x_ff;
   logic [CW-1:0]              s9_c_ff;
   hms_type                    s9_hms_ff;

   always_comb begin
      s9_dprod = (CW+11)'(s8_c_ff) * (CW+11)'(D_MUL);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[8]) begin
         s9_x_ff   <= s8_b_ff[XW-1:0] - s9_dprod[2 +: XW];
         s9_c_ff   <= s8_c_ff;
         s9_hms_ff <= s8_hms_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 10: e = floor(10000x / 306001)
   // ---------------------------------------------------------------------
   logic [XW+37:0]             s10_eprod;
   logic [EW-1:0]              s10_e_ff;
   logic [XW-1:0]              s10_x_ff;
   logic [CW-1:0]              s10_c_ff;
   hms_type                    s10_hms_ff;

   always_comb begin
      s10_eprod = (XW+38)'(s9_x_ff) * (XW+38)'(E_RECIP);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[9]) begin
         s10_e_ff   <= s10_eprod[E_SH +: EW];
         s10_x_ff   <= s9_x_ff;
         s10_c_ff   <= s9_c_ff;
         s10_hms_ff <= s9_hms_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 11: day, month, year into the response register
   // ---------------------------------------------------------------------
   logic [XW-1:0]              s11_day_full;
   logic                       s11_early;
   logic [MONTH_W-1:0]         s11_month_in;
   logic signed [CW:0]         s11_c_s;
   logic signed [CW:0]         s11_year_full;

   always_comb begin
      s11_day_full = s10_x_ff - month_start(s10_e_ff);
      // e of 14 or 15 means January or February of the next civil year
      s11_early    = (s10_e_ff >= EW'(MONTH_WRAP));
      s11_month_in = s11_early ? (s10_e_ff - EW'(MONTH_WRAP - 1))
                               : (s10_e_ff - EW'(1));
      s11_c_s      = $signed({1'b0, s10_c_ff});
      s11_year_full = s11_early ? (s11_c_s - (CW+1)'(YEAR_BIAS_EARLY))
                                : (s11_c_s - (CW+1)'(YEAR_BIAS_LATE));
   end

   always_ff @(posedge clock) begin
      if (ctl.load[10]) begin
         rsp_year         <= s11_year_full[YEAR_W-1:0];
         rsp_month        <= s11_month_in;
         rsp_day_of_month <= s11_day_full[DAY_W-1:0];
         rsp_hour         <= s10_hms_ff.hour;
         rsp_minute       <= s10_hms_ff.minute;
         rsp_second       <= s10_hms_ff.second;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/s2cd_checker.sv =====
// Port-level checks for seconds_to_calendar_date, attached with a bind.
// Depends on s2cd_pkg for the response field widths.
`default_nettype none

module s2cd_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic signed [s2cd_pkg::YEAR_W-1:0]  rsp_year,
   input  wire logic [s2cd_pkg::MONTH_W-1:0]        rsp_month,
   input  wire logic [s2cd_pkg::DAY_W-1:0]          rsp_day_of_month,
   input  wire logic [s2cd_pkg::HOUR_W-1:0]         rsp_hour,
   input  wire logic [s2cd_pkg::MINUTE_W-1:0]       rsp_minute,
   input  wire logic [s2cd_pkg::SECOND_W-1:0]       rsp_second
);
   import s2cd_pkg::*;

   // nothing leaves the pipe in the cycle after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a free output slot means the input side can take a transfer
   a_no_bubble_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled with output free");

   // decoded fields stay in calendar range
   a_field_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= MONTH_W'(1)) && (rsp_month <= MONTH_W'(12)) &&
                    (rsp_day_of_month >= DAY_W'(1)) &&
                    (rsp_hour <= HOUR_W'(23)) &&
                    (rsp_minute <= MINUTE_W'(59)) && (rsp_second <= SECOND_W'(59)))
      else $error("response field out of range");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_year) &&
         $stable(rsp_month) && $stable(rsp_day_of_month) && $stable(rsp_hour) &&
         $stable(rsp_minute) && $stable(rsp_second))
      else $error("stalled response changed");

   // keep the input handshake visible to the checker
   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   a_xfer_clean: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> req_ready)
      else $error("request transfer without ready");

endmodule

bind seconds_to_calendar_date s2cd_checker u_s2cd_checker (.*);

`default_nettype wire
